[rtl/cpsu_pkg.sv]
// Shared widths and pipeline context type for the circle pair separation unit.
`timescale 1ns / 1ps
package cpsu_pkg;
    localparam int CW    = 20;        // coordinate width
    localparam int RW    = 18;        // radius width
    localparam int SW    = RW + 1;    // radius sum width
    localparam int SQW   = 42;        // squared length width, padded to even
    localparam int DW    = SQW / 2;   // distance width, one bit per root cell
    localparam int REMW  = DW + 3;    // root remainder width
    localparam int OVW   = SW;        // overlap width
    localparam int DENW  = CW;        // divisor width (twice the distance)
    localparam int NUMW  = CW + OVW;  // product width
    localparam int QW    = 20;        // quotient bits, one per divide cell
    localparam int DRW   = DENW + 1;  // divide remainder width

    typedef struct packed {
        logic signed [CW-1:0] x1;
        logic signed [CW-1:0] y1;
        logic signed [CW-1:0] x2;
        logic signed [CW-1:0] y2;
        logic [CW-1:0]        adx;
        logic [CW-1:0]        ady;
        logic                 sx;
        logic                 sy;
        logic [SW-1:0]        rsum;
        logic                 hit;
        logic                 mv;
    } t_ctx;
endpackage

[rtl/cpsu_sqrt_cell.sv]
// One cell of the square root chain: settles one bit of the distance.
`timescale 1ns / 1ps
module cpsu_sqrt_cell
    import cpsu_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  t_ctx            i_ctx,
    input  logic [SQW-1:0]  i_rad,
    input  logic [REMW-1:0] i_rem,
    input  logic [DW-1:0]   i_root,
    output logic            o_valid,
    output t_ctx            o_ctx,
    output logic [SQW-1:0]  o_rad,
    output logic [REMW-1:0] o_rem,
    output logic [DW-1:0]   o_root
);
    logic [REMW-1:0] rem_sh;
    logic [REMW-1:0] trial;
    logic            ge;

    // bring down two radicand bits and try the next root bit
    assign rem_sh = {i_rem[REMW-3:0], i_rad[SQW-1 -: 2]};
    assign trial  = {{(REMW-DW-2){1'b0}}, i_root, 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

    // advance the data one cell
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_ctx  <= i_ctx;
            o_rad  <= {i_rad[SQW-3:0], 2'b00};
            o_rem  <= ge ? (rem_sh - trial) : rem_sh;
            o_root <= {i_root[DW-2:0], ge};
        end
    end
endmodule

[rtl/cpsu_div_cell.sv]
// One cell of the divide chain: settles one quotient bit for both axes.
`timescale 1ns / 1ps
module cpsu_div_cell
    import cpsu_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  t_ctx                 i_ctx,
    input  logic [DENW-1:0]      i_den,
    input  logic [1:0][QW-1:0]   i_num,
    input  logic [1:0][DRW-1:0]  i_rem,
    input  logic [1:0][QW-1:0]   i_q,
    output logic                 o_valid,
    output t_ctx                 o_ctx,
    output logic [DENW-1:0]      o_den,
    output logic [1:0][QW-1:0]   o_num,
    output logic [1:0][DRW-1:0]  o_rem,
    output logic [1:0][QW-1:0]   o_q
);
    logic [1:0][DRW-1:0] rem_sh;
    logic [1:0]          ge;

    // shift in one dividend bit per lane and subtract where it fits
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            rem_sh[l] = {i_rem[l][DRW-2:0], i_num[l][QW-1]};
            ge[l]     = (rem_sh[l] >= {1'b0, i_den});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_ctx <= i_ctx;
            o_den <= i_den;
            for (int l = 0; l < 2; l++) begin
                o_num[l] <= {i_num[l][QW-2:0], 1'b0};
                o_rem[l] <= ge[l] ? (rem_sh[l] - {1'b0, i_den}) : rem_sh[l];
                o_q[l]   <= {i_q[l][QW-2:0], ge[l]};
            end
        end
    end
endmodule

[rtl/circle_pair_separation_unit.sv]
// Top level of the circle pair separation unit: operand stages, root and divide chains.
`timescale 1ns / 1ps
// Takes one circle pair per cycle and returns one result per pair, in order, through
// 46 register stages (input register, squaring, 21 square root cells, overlap stage,
// product stage, 20 divide cells, output register). Throughput is one pair per clock;
// the whole pipeline holds while a result waits on i_ready, so o_ready follows i_ready
// whenever a result is pending.
module circle_pair_separation_unit
    import cpsu_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic signed [CW-1:0] i_first_x,
    input  logic signed [CW-1:0] i_first_y,
    input  logic [RW-1:0]        i_first_radius,
    input  logic signed [CW-1:0] i_second_x,
    input  logic signed [CW-1:0] i_second_y,
    input  logic [RW-1:0]        i_second_radius,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic signed [CW-1:0] o_new_first_x,
    output logic signed [CW-1:0] o_new_first_y,
    output logic signed [CW-1:0] o_new_second_x,
    output logic signed [CW-1:0] o_new_second_y,
    output logic                 o_overlapping
);
    function automatic logic signed [CW-1:0] sat(input logic signed [CW+1:0] v);
        logic signed [CW+1:0] hi;
        logic signed [CW+1:0] lo;
        hi = (CW+2)'((1 << (CW-1)) - 1);
        lo = -(CW+2)'(1 << (CW-1));
        if (v > hi) return hi[CW-1:0];
        else if (v < lo) return lo[CW-1:0];
        else return v[CW-1:0];
    endfunction

    logic en;
    assign en      = !o_valid || i_ready;
    assign o_ready = en;

    // stage 0: center difference and radius sum
    logic signed [CW:0] dx, dy;
    t_ctx n_c0, r_c0;
    logic r_v0;
    always_comb begin
        dx          = {i_second_x[CW-1], i_second_x} - {i_first_x[CW-1], i_first_x};
        dy          = {i_second_y[CW-1], i_second_y} - {i_first_y[CW-1], i_first_y};
        n_c0.x1     = i_first_x;
        n_c0.y1     = i_first_y;
        n_c0.x2     = i_second_x;
        n_c0.y2     = i_second_y;
        n_c0.sx     = dx[CW];
        n_c0.sy     = dy[CW];
        n_c0.adx    = dx[CW] ? CW'(-dx) : dx[CW-1:0];
        n_c0.ady    = dy[CW] ? CW'(-dy) : dy[CW-1:0];
        n_c0.rsum   = SW'(i_first_radius) + SW'(i_second_radius);
        n_c0.hit    = 1'b0;
        n_c0.mv     = 1'b0;
    end

    // stage 1: squares
    t_ctx r_c1;
    logic r_v1;
    logic [2*CW-1:0] r_sqx, r_sqy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else if (en) begin
            r_v0 <= i_valid;
            r_v1 <= r_v0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c0  <= n_c0;
            r_c1  <= r_c0;
            r_sqx <= r_c0.adx * r_c0.adx;
            r_sqy <= r_c0.ady * r_c0.ady;
        end
    end

    // square root chain
    logic [DW:0]             sq_v;
    t_ctx                    sq_c    [DW+1];
    logic [DW:0][SQW-1:0]    sq_rad;
    logic [DW:0][REMW-1:0]   sq_rem;
    logic [DW:0][DW-1:0]     sq_root;

    assign sq_v[0]    = r_v1;
    assign sq_c[0]    = r_c1;
    assign sq_rad[0]  = SQW'(r_sqx) + SQW'(r_sqy);
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;

    for (genvar k = 0; k < DW; k++) begin : g_sqrt
        cpsu_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (sq_v[k]),
            .i_ctx   (sq_c[k]),
            .i_rad   (sq_rad[k]),
            .i_rem   (sq_rem[k]),
            .i_root  (sq_root[k]),
            .o_valid (sq_v[k+1]),
            .o_ctx   (sq_c[k+1]),
            .o_rad   (sq_rad[k+1]),
            .o_rem   (sq_rem[k+1]),
            .o_root  (sq_root[k+1])
        );
    end

    // stage 2: overlap test, overlap and divisor
    logic [DW-1:0]   dlen;
    logic            hit;
    logic [DW:0]     ovl_full;
    t_ctx            n_c2, r_c2;
    logic            r_v2;
    logic [OVW-1:0]  r_ovl;
    logic [DENW-1:0] r_den2;

    always_comb begin
        dlen     = sq_root[DW];
        hit      = ({{(DW-SW){1'b0}}, sq_c[DW].rsum} > dlen);
        ovl_full = {{(DW-SW+1){1'b0}}, sq_c[DW].rsum} - {1'b0, dlen};
        n_c2     = sq_c[DW];
        n_c2.hit = hit;
        n_c2.mv  = hit && (dlen != '0);
    end

    // stage 3: products
    t_ctx            r_c3;
    logic            r_v3;
    logic [NUMW-1:0] r_numx, r_numy;
    logic [DENW-1:0] r_den3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (en) begin
            r_v2 <= sq_v[DW];
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c2   <= n_c2;
            r_ovl  <= ovl_full[OVW-1:0];
            r_den2 <= {dlen[DENW-2:0], 1'b0};
            r_c3   <= r_c2;
            r_numx <= r_c2.adx * r_ovl;
            r_numy <= r_c2.ady * r_ovl;
            r_den3 <= r_den2;
        end
    end

    // divide chain, both axes side by side
    logic [QW:0]                  dv_v;
    t_ctx                         dv_c   [QW+1];
    logic [QW:0][DENW-1:0]        dv_den;
    logic [QW:0][1:0][QW-1:0]     dv_num;
    logic [QW:0][1:0][DRW-1:0]    dv_rem;
    logic [QW:0][1:0][QW-1:0]     dv_q;

    assign dv_v[0]      = r_v3;
    assign dv_c[0]      = r_c3;
    assign dv_den[0]    = r_den3;
    assign dv_num[0][0] = r_numx[QW-1:0];
    assign dv_num[0][1] = r_numy[QW-1:0];
    assign dv_rem[0][0] = DRW'(r_numx[NUMW-1:QW]);
    assign dv_rem[0][1] = DRW'(r_numy[NUMW-1:QW]);
    assign dv_q[0]      = '0;

    for (genvar k = 0; k < QW; k++) begin : g_div
        cpsu_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (dv_v[k]),
            .i_ctx   (dv_c[k]),
            .i_den   (dv_den[k]),
            .i_num   (dv_num[k]),
            .i_rem   (dv_rem[k]),
            .i_q     (dv_q[k]),
            .o_valid (dv_v[k+1]),
            .o_ctx   (dv_c[k+1]),
            .o_den   (dv_den[k+1]),
            .o_num   (dv_num[k+1]),
            .o_rem   (dv_rem[k+1]),
            .o_q     (dv_q[k+1])
        );
    end

    // output stage: signed offsets and saturated positions
    t_ctx                 fc;
    logic signed [CW+1:0] offx, offy, magx, magy;
    always_comb begin
        fc   = dv_c[QW];
        magx = fc.mv ? $signed({2'b00, dv_q[QW][0]}) : '0;
        magy = fc.mv ? $signed({2'b00, dv_q[QW][1]}) : '0;
        offx = fc.sx ? -magx : magx;
        offy = fc.sy ? -magy : magy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (en) begin
            o_valid <= dv_v[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_new_first_x  <= sat({{2{fc.x1[CW-1]}}, fc.x1} - offx);
            o_new_first_y  <= sat({{2{fc.y1[CW-1]}}, fc.y1} - offy);
            o_new_second_x <= sat({{2{fc.x2[CW-1]}}, fc.x2} + offx);
            o_new_second_y <= sat({{2{fc.y2[CW-1]}}, fc.y2} + offy);
            o_overlapping  <= fc.hit;
        end
    end
endmodule

[rtl/cpsu_checker.sv]
// Port checker for the circle pair separation unit and its bind.
`timescale 1ns / 1ps
module cpsu_checker
    import cpsu_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_ready,
    input logic                 o_valid,
    input logic                 i_ready,
    input logic signed [CW-1:0] o_new_first_x,
    input logic signed [CW-1:0] o_new_second_x,
    input logic                 o_overlapping
);
    // reset empties the pipeline
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // input side is open exactly when the output register can move
    a_ready_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready == (!o_valid || i_ready))
        else $error("input ready does not track output stall");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_new_first_x)
            && $stable(o_new_second_x) && $stable(o_overlapping))
        else $error("stalled result changed");
endmodule

bind circle_pair_separation_unit cpsu_checker u_cpsu_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_ready        (o_ready),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_new_first_x  (o_new_first_x),
    .o_new_second_x (o_new_second_x),
    .o_overlapping  (o_overlapping)
);
